// ===== rtl/mnos_pkg.sv =====
// Shared types and constants for the note-off scheduler.
package mnos_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 32;
   localparam int POS_W = 6;

   localparam logic [1:0] MODE_ADD     = 2'd0;
   localparam logic [1:0] MODE_ADVANCE = 2'd1;
   localparam logic [1:0] MODE_FLUSH   = 2'd2;

   localparam logic [1:0] KIND_EVENT  = 2'd0;
   localparam logic [1:0] KIND_STATUS = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [6:0] VEL_ZERO        = 7'h00;

   typedef struct packed {
      logic [3:0]  chan;
      logic [6:0]  key;
      logic [7:0]  vel;
      logic [31:0] left;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_SHIFT,
      CELL_SUB
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [POS_W-1:0] pos;
      logic [31:0]      step;
      entry_type        entry;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_MIN,
      ST_SUB,
      ST_EMIT,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/mnos_cell.sv =====
// One table cell: holds a note, loads, shifts toward the head or subtracts.
module mnos_cell #(
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  mnos_pkg::cell_ctl_type ctl,
   input  mnos_pkg::entry_type   next_entry,
   input  mnos_pkg::entry_type   recirc_entry,
   output mnos_pkg::entry_type   entry
);
   import mnos_pkg::*;

   entry_type entry_ff, entry_in;
   logic      at_pos, below_pos;

   assign at_pos    = (ctl.pos == POS_W'(IDX));
   assign below_pos = (POS_W'(IDX) < ctl.pos);

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         CELL_LOAD: begin
            if (at_pos) entry_in = ctl.entry;
         end
         CELL_SHIFT: begin
            if (below_pos) entry_in = next_entry;
            else if (at_pos) entry_in = recirc_entry;
         end
         CELL_SUB: begin
            entry_in.left = entry_ff.left - ctl.step;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/midi_note_off_scheduler.sv =====
// Top level of the note-off scheduler: control sequencer over a chain of note cells.
//
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | mode, channel, note, velocity, ticks, shorten
//  rsp_    | out       | rsp_valid/rsp_stall  | kind, delta, status, key, velocity, status fields
//
// Add and unused-mode items are answered straight from the idle state. Advance
// and flush items walk the note chain through its head cell: a flush item first
// makes a pre-pass over every stored note, then for each expiry batch comes a
// minimum pass, a subtract step and an emit pass, then one done item.
// Reset is synchronous and clears only the state, the note count and the
// result valid flag; note cells are not cleared, entries at or past the count
// are never used. A stalled result pauses the chain only when the head note must emit.
module midi_note_off_scheduler #(
   parameter int TABLE_DEPTH = mnos_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_channel,
   input  logic [6:0]  req_note_number,
   input  logic [7:0]  req_release_velocity,
   input  logic [31:0] req_ticks,
   input  logic        req_shorten,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_delta_ticks,
   output logic [7:0]  rsp_status_byte,
   output logic [6:0]  rsp_key,
   output logic [6:0]  rsp_off_velocity,
   output logic        rsp_add_ok,
   output logic [31:0] rsp_remaining_ticks,
   output logic [5:0]  rsp_expired_count,
   output logic        rsp_last
);
   import mnos_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // chain of note cells; cell 0 is the head
   entry_type    cell_q [TABLE_DEPTH];
   cell_ctl_type ctl;
   entry_type    recirc;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      entry_type nxt;
      if (g < TABLE_DEPTH - 1) begin : g_mid
         assign nxt = cell_q[g+1];
      end else begin : g_end
         assign nxt = recirc;
      end
      mnos_cell #(.IDX(g)) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .next_entry   (nxt),
         .recirc_entry (recirc),
         .entry        (cell_q[g])
      );
   end

   state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] iter_ff, iter_in;
   logic [31:0] budget_ff, budget_in;
   logic [32:0] step_ff, step_in;
   logic        first_ff, first_in;
   logic        cut_ff, cut_in;
   logic [5:0]  expired_ff, expired_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] delta_ff, delta_in;
   logic [7:0]  status_ff, status_in;
   logic [6:0]  key_ff, key_in;
   logic [6:0]  vel_ff, vel_in;
   logic        ok_ff, ok_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;

   entry_type   head;
   logic        out_free, in_acc, last_iter, head_zero, emit_wait, table_full;
   logic [32:0] step_cand;
   logic [CNT_W-1:0] count_dec;

   assign head       = cell_q[0];
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign in_acc     = req_valid && !req_stall;
   assign last_iter  = (iter_ff == CNT_W'(1));
   assign head_zero  = (head.left == 32'd0);
   assign emit_wait  = (state_ff == ST_EMIT) && head_zero && !out_free;
   assign table_full = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign step_cand  = ({1'b0, head.left} < step_ff) ? {1'b0, head.left} : step_ff;
   assign count_dec  = count_ff - CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_acc && (req_mode == MODE_ADVANCE || req_mode == MODE_FLUSH)) begin
               if (count_ff == '0) state_in = ST_DONE;
               else if (req_mode == MODE_ADVANCE) state_in = ST_MIN;
               else state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (last_iter) state_in = ST_MIN;
         end
         ST_MIN: begin
            if (last_iter) state_in = (step_cand > {1'b0, budget_ff}) ? ST_DONE : ST_SUB;
         end
         ST_SUB: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!emit_wait && last_iter) begin
               if (head_zero && count_dec == '0) state_in = ST_DONE;
               else state_in = ST_MIN;
            end
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath, cell control and result register
   always_comb begin
      count_in   = count_ff;
      iter_in    = iter_ff;
      budget_in  = budget_ff;
      step_in    = step_ff;
      first_in   = first_ff;
      cut_in     = cut_ff;
      expired_in = expired_ff;

      ctl        = '{op: CELL_HOLD, pos: POS_W'(count_dec), step: step_ff[31:0],
                     entry: head};
      recirc     = head;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in   = kind_ff;
      delta_in  = delta_ff;
      status_in = status_ff;
      key_in    = key_ff;
      vel_in    = vel_ff;
      ok_in     = ok_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      last_in   = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_acc) begin
               budget_in  = req_ticks;
               cut_in     = req_shorten;
               expired_in = '0;
               iter_in    = count_ff;
               step_in    = {1'b0, req_ticks} + 33'd1;
               rsp_valid_in = 1'b1;
               kind_in = KIND_DONE;  delta_in = '0; status_in = '0; key_in = '0;
               vel_in  = '0; ok_in = 1'b0; rem_in = '0; cnt_in = '0; last_in = 1'b1;
               if (req_mode == MODE_ADD) begin
                  kind_in = KIND_STATUS;
                  if (!table_full) begin
                     ok_in     = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                     ctl.op    = CELL_LOAD;
                     ctl.pos   = POS_W'(count_ff);
                     ctl.entry = '{chan: req_channel, key: req_note_number,
                                   vel: req_release_velocity, left: req_ticks};
                  end
               end else if (req_mode == MODE_ADVANCE || req_mode == MODE_FLUSH) begin
                  rsp_valid_in = rsp_valid_ff && rsp_stall;
               end else begin
                  rem_in = req_ticks;
               end
            end
         end
         ST_FLUSH: begin
            // cut the note to the timestamp, or stretch the timestamp
            ctl.op  = CELL_SHIFT;
            iter_in = iter_ff - CNT_W'(1);
            if (head.left > budget_ff) begin
               if (cut_ff) recirc.left = budget_ff;
               else budget_in = head.left;
            end
            if (last_iter) begin
               iter_in = count_ff;
               step_in = {1'b0, budget_in} + 33'd1;
            end
         end
         ST_MIN: begin
            ctl.op  = CELL_SHIFT;
            iter_in = iter_ff - CNT_W'(1);
            step_in = step_cand;
         end
         ST_SUB: begin
            ctl.op    = CELL_SUB;
            budget_in = budget_ff - step_ff[31:0];
            first_in  = 1'b1;
            iter_in   = count_ff;
         end
         ST_EMIT: begin
            if (!emit_wait) begin
               ctl.op  = CELL_SHIFT;
               iter_in = iter_ff - CNT_W'(1);
               if (head_zero) begin
                  count_in   = count_dec;
                  expired_in = expired_ff + 6'd1;
                  first_in   = 1'b0;
                  rsp_valid_in = 1'b1;
                  kind_in  = KIND_EVENT;
                  delta_in = first_ff ? step_ff[31:0] : 32'd0;
                  key_in   = head.key;
                  ok_in = 1'b0; rem_in = '0; cnt_in = '0; last_in = 1'b0;
                  if (head.vel[7]) begin
                     status_in = STATUS_NOTE_ON | {4'h0, head.chan};
                     vel_in    = VEL_ZERO;
                  end else begin
                     status_in = STATUS_NOTE_OFF | {4'h0, head.chan};
                     vel_in    = head.vel[6:0];
                  end
               end
               if (last_iter) begin
                  iter_in = count_in;
                  step_in = {1'b0, budget_ff} + 33'd1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in = KIND_DONE; delta_in = '0; status_in = '0; key_in = '0;
               vel_in  = '0; ok_in = 1'b0; rem_in = budget_ff; cnt_in = expired_ff;
               last_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff    <= iter_in;
      budget_ff  <= budget_in;
      step_ff    <= step_in;
      first_ff   <= first_in;
      cut_ff     <= cut_in;
      expired_ff <= expired_in;
      kind_ff    <= kind_in;
      delta_ff   <= delta_in;
      status_ff  <= status_in;
      key_ff     <= key_in;
      vel_ff     <= vel_in;
      ok_ff      <= ok_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      last_ff    <= last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_delta_ticks     = delta_ff;
   assign rsp_status_byte     = status_ff;
   assign rsp_key             = key_ff;
   assign rsp_off_velocity    = vel_ff;
   assign rsp_add_ok          = ok_ff;
   assign rsp_remaining_ticks = rem_ff;
   assign rsp_expired_count   = cnt_ff;
   assign rsp_last            = last_ff;

endmodule

// ===== rtl/mnos_checker.sv =====
// Port-level checks for the note-off scheduler, bound to the top level.
module mnos_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_status_byte,
   input logic        rsp_last
);
   import mnos_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind))
      else $error("stalled item changed");

   a_event_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_EVENT |-> !rsp_last)
      else $error("event marked last");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_STATUS || rsp_kind == KIND_DONE) |-> rsp_last)
      else $error("closing item not marked last");

   a_event_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_EVENT |-> rsp_status_byte[7:5] == 3'b100)
      else $error("bad event status byte");

endmodule

bind midi_note_off_scheduler mnos_checker u_mnos_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_status_byte (rsp_status_byte),
   .rsp_last        (rsp_last)
);
